### rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Condition that holds at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) (expr)) else $error("assertion failed");

`endif

### rtl/p2c_pkg.sv
// ---------------------------------------------------------------------------
// p2c_pkg
// Shared constants, register codes and the arctangent table of the
// polar-to-Cartesian address map.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package p2c_pkg;

  localparam int MAX_WIDTH    = 4096;
  localparam int SQRT_STEPS   = 38;
  localparam int RAD_W        = 2 * SQRT_STEPS;
  localparam int CORDIC_STEPS = 31;
  localparam int XY_W         = 39;
  localparam int CW           = 45;
  localparam int RANGE_LAT    = SQRT_STEPS + 6;
  localparam int ANGLE_LAT    = CORDIC_STEPS + 8;
  localparam int ALIGN_DLY    = RANGE_LAT - ANGLE_LAT;
  localparam int TOTAL_LAT    = RANGE_LAT + 1;

  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;

  // Configuration register indexes
  localparam logic [2:0] REG_IMAGE_WIDTH     = 3'd0;
  localparam logic [2:0] REG_PIXEL_SIZE      = 3'd1;
  localparam logic [2:0] REG_BINS_PER_METER  = 3'd2;
  localparam logic [2:0] REG_FIRST_AZIMUTH   = 3'd3;
  localparam logic [2:0] REG_ROWS_PER_RADIAN = 3'd4;
  localparam logic [2:0] REG_CROSSOVER_PAD   = 3'd5;

  // Binary angles, a full turn is 2^32
  localparam logic [31:0] ANG_ZERO = 32'h0000_0000;
  localparam logic [31:0] ANG_HALF = 32'h8000_0000;
  localparam logic [31:0] ANG_QTR  = 32'h4000_0000;
  localparam logic [31:0] ANG_3QTR = 32'hC000_0000;

  // atan(2^-i) in binary angle units
  function automatic logic [31:0] atan_tab(input int i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h20000000;  1:  v = 32'h12E4051E;  2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;  4:  v = 32'h028B0D43;  5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;  7:  v = 32'h00517C55;  8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;  10: v = 32'h000A2F98;  11: v = 32'h000517CC;
      12: v = 32'h00028BE6;  13: v = 32'h000145F3;  14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;  16: v = 32'h000028BE;  17: v = 32'h0000145F;
      18: v = 32'h00000A30;  19: v = 32'h00000518;  20: v = 32'h0000028C;
      21: v = 32'h00000146;  22: v = 32'h000000A3;  23: v = 32'h00000051;
      24: v = 32'h00000029;  25: v = 32'h00000014;  26: v = 32'h0000000A;
      27: v = 32'h00000005;  28: v = 32'h00000003;  29: v = 32'h00000001;
      30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

### rtl/p2c_sqrt.sv
// ---------------------------------------------------------------------------
// p2c_sqrt
// Pipelined restoring square root, one root bit per stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module p2c_sqrt (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic [p2c_pkg::RAD_W-1:0]       radicand,
  output logic                            out_valid,
  output logic [p2c_pkg::SQRT_STEPS-1:0]  root
);
  import p2c_pkg::*;

  localparam int REM_W = SQRT_STEPS + 3;

  logic [SQRT_STEPS:0]   vld;
  logic [RAD_W-1:0]      rad [0:SQRT_STEPS];
  logic [REM_W-1:0]      rem [0:SQRT_STEPS];
  logic [SQRT_STEPS-1:0] rt  [0:SQRT_STEPS];

  assign vld[0] = in_valid;
  assign rad[0] = radicand;
  assign rem[0] = '0;
  assign rt[0]  = '0;

  genvar k;
  generate
    for (k = 0; k < SQRT_STEPS; k++) begin : g_step
      logic [REM_W-1:0] shifted;
      logic [REM_W-1:0] trial;
      assign shifted = {rem[k][REM_W-3:0], rad[k][RAD_W-1-2*k -: 2]};
      assign trial   = {1'b0, rt[k], 2'b01};

      // Bring down two radicand bits and try the next root bit
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k+1] <= 1'b0;
        end else begin
          vld[k+1] <= vld[k];
        end
        rad[k+1] <= rad[k];
        if (shifted >= trial) begin
          rem[k+1] <= shifted - trial;
          rt[k+1]  <= {rt[k][SQRT_STEPS-2:0], 1'b1};
        end else begin
          rem[k+1] <= shifted;
          rt[k+1]  <= {rt[k][SQRT_STEPS-2:0], 1'b0};
        end
      end
    end
  endgenerate

  assign out_valid = vld[SQRT_STEPS];
  assign root      = rt[SQRT_STEPS];

endmodule

### rtl/p2c_cordic.sv
// ---------------------------------------------------------------------------
// p2c_cordic
// Vectoring CORDIC: axis cases, normalising shift, then one micro-rotation
// per stage, giving the binary angle of (x, y).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module p2c_cordic (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic signed [p2c_pkg::XY_W-1:0] x,
  input  logic signed [p2c_pkg::XY_W-1:0] y,
  output logic                           out_valid,
  output logic [31:0]                    angle
);
  import p2c_pkg::*;

  localparam int M_W = 41;

  // Axis handling and fold into the right half plane
  logic                 p_vld, p_spec;
  logic [31:0]          p_spec_val, p_base;
  logic signed [CW-1:0] p_x, p_y;
  logic [M_W-1:0]       p_m;
  logic signed [XY_W-1:0] fx, fy, ay;

  always_comb begin
    fx = (x < 0) ? -x : x;
    fy = (x < 0) ? -y : y;
    ay = (fy < 0) ? -fy : fy;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_vld <= 1'b0;
    end else begin
      p_vld <= in_valid;
    end
    p_spec <= (x == 0) || (y == 0);
    if (y == 0) begin
      p_spec_val <= (x < 0) ? ANG_HALF : ANG_ZERO;
    end else begin
      p_spec_val <= (y > 0) ? ANG_QTR : ANG_3QTR;
    end
    p_base <= (x < 0) ? ANG_HALF : ANG_ZERO;
    p_x    <= CW'(fx);
    p_y    <= CW'(fy);
    p_m    <= M_W'(fx[XY_W-2:0] | ay[XY_W-2:0]);
  end

  // Normalise over two stages: shifts of 32, 16, 8 then 4, 2, 1
  logic                 n_vld  [0:2];
  logic                 n_spec [0:2];
  logic [31:0]          n_sv   [0:2];
  logic [31:0]          n_base [0:2];
  logic signed [CW-1:0] n_x    [0:2];
  logic signed [CW-1:0] n_y    [0:2];
  logic [M_W-1:0]       n_m    [0:2];

  assign n_vld[0]  = p_vld;
  assign n_spec[0] = p_spec;
  assign n_sv[0]   = p_spec_val;
  assign n_base[0] = p_base;
  assign n_x[0]    = p_x;
  assign n_y[0]    = p_y;
  assign n_m[0]    = p_m;

  genvar g;
  generate
    for (g = 0; g < 2; g++) begin : g_norm
      localparam int BASE = (g == 0) ? 32 : 4;
      logic signed [CW-1:0] sx, sy;
      logic [M_W-1:0]       sm;

      always_comb begin
        sx = n_x[g];
        sy = n_y[g];
        sm = n_m[g];
        for (int j = 0; j < 3; j++) begin
          if ((sm >> (M_W - (BASE >> j))) == '0) begin
            sx = sx <<< (BASE >> j);
            sy = sy <<< (BASE >> j);
            sm = sm << (BASE >> j);
          end
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          n_vld[g+1] <= 1'b0;
        end else begin
          n_vld[g+1] <= n_vld[g];
        end
        n_spec[g+1] <= n_spec[g];
        n_sv[g+1]   <= n_sv[g];
        n_base[g+1] <= n_base[g];
        n_x[g+1]    <= sx;
        n_y[g+1]    <= sy;
        n_m[g+1]    <= sm;
      end
    end
  endgenerate

  // Micro-rotations
  logic                 c_vld  [0:CORDIC_STEPS];
  logic                 c_spec [0:CORDIC_STEPS];
  logic [31:0]          c_sv   [0:CORDIC_STEPS];
  logic [31:0]          c_acc  [0:CORDIC_STEPS];
  logic signed [CW-1:0] c_x    [0:CORDIC_STEPS];
  logic signed [CW-1:0] c_y    [0:CORDIC_STEPS];

  assign c_vld[0]  = n_vld[2];
  assign c_spec[0] = n_spec[2];
  assign c_sv[0]   = n_sv[2];
  assign c_acc[0]  = n_base[2];
  assign c_x[0]    = n_x[2];
  assign c_y[0]    = n_y[2];

  genvar i;
  generate
    for (i = 0; i < CORDIC_STEPS; i++) begin : g_rot
      always_ff @(posedge clk) begin
        if (rst) begin
          c_vld[i+1] <= 1'b0;
        end else begin
          c_vld[i+1] <= c_vld[i];
        end
        c_spec[i+1] <= c_spec[i];
        c_sv[i+1]   <= c_sv[i];
        if (c_y[i] > 0) begin
          c_x[i+1]   <= c_x[i] + (c_y[i] >>> i);
          c_y[i+1]   <= c_y[i] - (c_x[i] >>> i);
          c_acc[i+1] <= c_acc[i] + atan_tab(i);
        end else begin
          c_x[i+1]   <= c_x[i] - (c_y[i] >>> i);
          c_y[i+1]   <= c_y[i] + (c_x[i] >>> i);
          c_acc[i+1] <= c_acc[i] - atan_tab(i);
        end
      end
    end
  endgenerate

  assign out_valid = c_vld[CORDIC_STEPS];
  assign angle     = c_spec[CORDIC_STEPS] ? c_sv[CORDIC_STEPS] : c_acc[CORDIC_STEPS];

endmodule

### rtl/p2c_range.sv
// ---------------------------------------------------------------------------
// p2c_range
// Range path: squared distance, square root, scale by bins per metre,
// remove the half bin and clamp.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module p2c_range (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [13:0] dx,
  input  logic signed [13:0] dy,
  input  logic [47:0]        ps_sq,
  input  logic [23:0]        bins_per_meter,
  output logic               out_valid,
  output logic [31:0]        range_index
);
  import p2c_pkg::*;

  logic signed [27:0] sq_x, sq_y, sq_sum;
  logic [27:0]        d2;
  logic [51:0]        q_lo, q_hi;
  logic [RAD_W-1:0]   sum;
  logic [2:0]         v;
  logic               s_vld;
  logic [SQRT_STEPS-1:0] root;
  logic [42:0]        p_lo, p_hi;
  logic [61:0]        r33, r_off;
  logic [2:0]         m;

  assign sq_x   = dx * dx;
  assign sq_y   = dy * dy;
  assign sq_sum = sq_x + sq_y;

  // Squared half-pixel distance, then times pixel size squared
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[1:0], in_valid};
    end
    d2   <= sq_sum;
    q_lo <= d2 * ps_sq[23:0];
    q_hi <= d2 * ps_sq[47:24];
    sum  <= {q_hi, 24'b0} + RAD_W'(q_lo);
  end

  p2c_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v[2]),
    .radicand (sum),
    .out_valid(s_vld),
    .root     (root)
  );

  assign r_off = r33 - 62'h1_0000_0000;

  // Scale, drop the half bin, clamp at zero and saturate
  always_ff @(posedge clk) begin
    if (rst) begin
      m <= '0;
    end else begin
      m <= {m[1:0], s_vld};
    end
    p_lo <= root[18:0] * bins_per_meter;
    p_hi <= root[37:19] * bins_per_meter;
    r33  <= {p_hi, 19'b0} + 62'(p_lo);
    if (r33 <= 62'h1_0000_0000) begin
      range_index <= '0;
    end else if (|r_off[61:49]) begin
      range_index <= '1;
    end else begin
      range_index <= r_off[48:17];
    end
  end

  assign out_valid = m[2];

endmodule

### rtl/p2c_angle.sv
// ---------------------------------------------------------------------------
// p2c_angle
// Angle path: metric x and y, CORDIC angle, radians, azimuth offset and
// scale to fractional polar rows.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module p2c_angle (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic signed [13:0] dx,
  input  logic signed [13:0] dy,
  input  logic [23:0]        pixel_size,
  input  logic [18:0]        first_azimuth,
  input  logic [23:0]        rows_per_radian,
  input  logic               crossover_pad,
  output logic               out_valid,
  output logic [31:0]        angle_index
);
  import p2c_pkg::*;

  logic                   x_vld;
  logic signed [XY_W-1:0] x, y;
  logic                   c_vld;
  logic [31:0]            bang;
  logic [3:0]             v;
  logic [63:0]            t_prod;
  logic signed [32:0]     diff;
  logic signed [57:0]     a_prod;
  logic signed [57:0]     a_shift;

  // Half-pixel offsets times pixel size
  always_ff @(posedge clk) begin
    if (rst) begin
      x_vld <= 1'b0;
    end else begin
      x_vld <= in_valid;
    end
    x <= dx * signed'({1'b0, pixel_size});
    y <= dy * signed'({1'b0, pixel_size});
  end

  p2c_cordic u_cordic (
    .clk      (clk),
    .rst      (rst),
    .in_valid (x_vld),
    .x        (x),
    .y        (y),
    .out_valid(c_vld),
    .angle    (bang)
  );

  assign a_shift = a_prod >>> 29;

  // Binary angle to radians, subtract first azimuth, scale to rows
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[2:0], c_vld};
    end
    t_prod      <= bang * TWO_PI_Q29;
    diff        <= signed'({1'b0, t_prod[63:32]}) - signed'({1'b0, first_azimuth, 13'b0});
    a_prod      <= diff * signed'({1'b0, rows_per_radian});
    angle_index <= a_shift[31:0] + (crossover_pad ? 32'h0001_0000 : 32'h0);
  end

  assign out_valid = v[3];

endmodule

### rtl/polar_to_cartesian_map.sv
// Polar-to-Cartesian address map. One pixel (row, column) is taken on every
// clock at which start is high; busy is high only during reset. Each pixel
// gives its fractional range and angle index, flagged by done for one cycle,
// in order; the latency is set by the 38-stage square-root pipeline of the
// range path. The receiver cannot stall the block, so done must be captured
// when it rises. Configuration writes are always ready and must land while
// no pixel is in flight.
// ---------------------------------------------------------------------------
// polar_to_cartesian_map
// Top level: configuration registers, pixel offsets, range and angle paths.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module polar_to_cartesian_map (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [11:0] pixel_row,
  input  logic [11:0] pixel_col,
  output logic        done,
  output logic [31:0] range_index,
  output logic [31:0] angle_index,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import p2c_pkg::*;

  logic [12:0] image_width;
  logic [23:0] pixel_size;
  logic [23:0] bins_per_meter;
  logic [18:0] first_azimuth;
  logic [23:0] rows_per_radian;
  logic        crossover_pad;
  logic [47:0] ps_sq;

  assign cfg_ready = 1'b1;
  assign busy      = rst;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= 13'd640;
      pixel_size      <= 24'd15624;
      bins_per_meter  <= 24'd1496269;
      first_azimuth   <= 19'd0;
      rows_per_radian <= 24'd4172000;
      crossover_pad   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:     image_width     <= cfg_data[12:0];
        REG_PIXEL_SIZE:      pixel_size      <= cfg_data;
        REG_BINS_PER_METER:  bins_per_meter  <= cfg_data;
        REG_FIRST_AZIMUTH:   first_azimuth   <= cfg_data[18:0];
        REG_ROWS_PER_RADIAN: rows_per_radian <= cfg_data;
        REG_CROSSOVER_PAD:   crossover_pad   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Hold pixel size squared for the range path
  always_ff @(posedge clk) begin
    ps_sq <= pixel_size * pixel_size;
  end

  // Offsets from the centre in half pixels
  logic [12:0]        w_clip;
  logic signed [13:0] c2;
  logic               s_vld;
  logic signed [13:0] dx, dy;

  assign w_clip = (image_width > 13'(MAX_WIDTH)) ? 13'(MAX_WIDTH) : image_width;
  assign c2     = signed'({1'b0, w_clip}) - 14'sd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld <= 1'b0;
    end else begin
      s_vld <= start && !busy;
    end
    dx <= c2 - signed'({1'b0, pixel_row, 1'b0});
    dy <= signed'({1'b0, pixel_col, 1'b0}) - c2;
  end

  logic        r_vld, a_vld;
  logic [31:0] a_val;

  p2c_range u_range (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (s_vld),
    .dx            (dx),
    .dy            (dy),
    .ps_sq         (ps_sq),
    .bins_per_meter(bins_per_meter),
    .out_valid     (r_vld),
    .range_index   (range_index)
  );

  p2c_angle u_angle (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_vld),
    .dx             (dx),
    .dy             (dy),
    .pixel_size     (pixel_size),
    .first_azimuth  (first_azimuth),
    .rows_per_radian(rows_per_radian),
    .crossover_pad  (crossover_pad),
    .out_valid      (a_vld),
    .angle_index    (a_val)
  );

  // Delay the shorter angle path to line up with the range path
  logic        d_vld [0:ALIGN_DLY];
  logic [31:0] d_ang [0:ALIGN_DLY];

  assign d_vld[0] = a_vld;
  assign d_ang[0] = a_val;

  genvar k;
  generate
    for (k = 0; k < ALIGN_DLY; k++) begin : g_dly
      always_ff @(posedge clk) begin
        if (rst) begin
          d_vld[k+1] <= 1'b0;
        end else begin
          d_vld[k+1] <= d_vld[k];
        end
        d_ang[k+1] <= d_ang[k];
      end
    end
  endgenerate

  assign done        = r_vld;
  assign angle_index = d_ang[ALIGN_DLY];

  `ASSERT_IMP(a_paths_aligned, 1'b1, d_vld[ALIGN_DLY] == r_vld)
  `ASSERT_IMP(a_fixed_latency, start && !busy, ##(TOTAL_LAT) done)
  `ASSERT_IMP(a_reset_flush, $past(rst), !done)
  `ASSERT_ALWAYS(a_busy_in_reset, busy == rst)

endmodule
